@@ rtl/pmm_pkg.sv @@
// Shared constants and types of the preemptible matrix multiply-accumulate block.
package pmm_pkg;

	// Default matrix size held in storage.
	localparam int MATRIX_DIM_DEF = 8;

	// Configuration register map and reset values.
	localparam logic REG_DIM_IN_USE   = 1'b0;
	localparam logic REG_ROWS_PER_RUN = 1'b1;
	localparam logic [3:0] DIM_IN_USE_RST   = 4'd8;
	localparam logic [3:0] ROWS_PER_RUN_RST = 4'd2;

	// Accumulator range, signed Q32.16 in 48 bits.
	localparam logic [47:0] ACC_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] ACC_MIN = 48'h8000_0000_0000;

	// Request codes carried by an item.
	typedef enum logic [1:0] {
		REQ_WR_A = 2'd0,
		REQ_WR_B = 2'd1,
		REQ_WR_C = 2'd2,
		REQ_RUN  = 2'd3
	} req_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_FETCH = 4'b0010,
		ST_MUL   = 4'b0100,
		ST_ACC   = 4'b1000
	} state_t;

endpackage

@@ rtl/preemptible_matrix_mac.sv @@
// Top level of the preemptible matrix multiply-accumulate block (C += A*B, row by row).
//
// Usage: an item is accepted when start is high and busy is low. req_type selects a
// write of one element of A, B or C (row, col, value in signed Q8.8; C is stored as
// Q32.16) or a run. A write leaves busy low, so writes may follow one another in
// every cycle. A run resumes at the saved row pointer and computes up
// to rows_per_run rows of C. Each updated C element appears on out_row, out_col and
// out_value for one cycle with out_valid high; last marks the final element of the
// run and complete marks the run that finished the final row, after which the
// pointer wraps to zero. One shared 16x16 multiplier and one 48-bit saturating adder
// do all the work: each product goes through three steps (memory read, multiply,
// accumulate). The element appears in the cycle after its final accumulate; the last
// element of a run appears in the first cycle that busy is low again. A run whose
// pointer lies outside the dimension in use emits nothing and clears the pointer.
// The receiver cannot stall results. Reset clears the pointer and the sequencer and
// loads dim_in_use with 8 and rows_per_run with 2; matrix contents are undefined
// until written. Registers sit on an APB port at byte addresses 0 and 4.
module preemptible_matrix_mac #(
	parameter int MATRIX_DIM = pmm_pkg::MATRIX_DIM_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// Command channel
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         req_type,
	input  logic [2:0]         row,
	input  logic [2:0]         col,
	input  logic signed [15:0] value,
	// Result channel
	output logic               out_valid,
	output logic [2:0]         out_row,
	output logic [2:0]         out_col,
	output logic signed [47:0] out_value,
	output logic               last,
	output logic               complete
);
	import pmm_pkg::*;

	localparam int IDX_W  = (MATRIX_DIM > 1) ? $clog2(MATRIX_DIM) : 1;
	localparam int CELLS  = MATRIX_DIM * MATRIX_DIM;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int CNT_W  = $clog2(MATRIX_DIM + 1);

	// Storage: A and B in Q8.8, C in Q32.16.
	logic signed [15:0] mem_a [CELLS];
	logic signed [15:0] mem_b [CELLS];
	logic signed [47:0] mem_c [CELLS];

	// Configuration registers and row pointer.
	logic [3:0]       dim_in_use_q;
	logic [3:0]       rows_per_run_q;
	logic [IDX_W-1:0] next_row_q;

	// Sequencer.
	state_t           state_q;
	logic [IDX_W-1:0] i_q, j_q, k_q;
	logic [CNT_W-1:0] rows_done_q;

	// Datapath registers.
	logic signed [15:0] a_rd_q, b_rd_q;
	logic signed [47:0] c_rd_q;
	logic signed [31:0] prod_q;
	logic signed [47:0] acc_q;

	// Result registers.
	logic               out_valid_q;
	logic [2:0]         out_row_q, out_col_q;
	logic signed [47:0] out_value_q;
	logic               last_q, complete_q;

	logic [CNT_W-1:0]  dim_eff, budget_eff;
	logic              accept, run_req, wr_in_range;
	logic [ADDR_W-1:0] wr_addr, a_raddr, b_raddr, c_raddr;
	logic              k_end, j_end, dim_end, run_end;
	logic [48:0]       sum_w;
	logic [47:0]       acc_next;
	logic              c_we;
	logic [ADDR_W-1:0] c_waddr;
	logic [47:0]       c_wdata;
	logic              cfg_wr;

	// Clamp the configuration counts to 1..MATRIX_DIM.
	always_comb begin
		if (dim_in_use_q == 4'd0)
			dim_eff = CNT_W'(1);
		else if (dim_in_use_q > 4'(MATRIX_DIM))
			dim_eff = CNT_W'(MATRIX_DIM);
		else
			dim_eff = CNT_W'(dim_in_use_q);
		if (rows_per_run_q == 4'd0)
			budget_eff = CNT_W'(1);
		else if (rows_per_run_q > 4'(MATRIX_DIM))
			budget_eff = CNT_W'(MATRIX_DIM);
		else
			budget_eff = CNT_W'(rows_per_run_q);
	end

	// Item decode and element addresses.
	assign accept      = start && (state_q == ST_IDLE);
	assign run_req     = accept && (req_type == REQ_RUN);
	assign wr_in_range = ({1'b0, row} < 4'(MATRIX_DIM)) && ({1'b0, col} < 4'(MATRIX_DIM));
	assign wr_addr     = ADDR_W'(row) * ADDR_W'(MATRIX_DIM) + ADDR_W'(col);
	assign a_raddr     = ADDR_W'(i_q) * ADDR_W'(MATRIX_DIM) + ADDR_W'(k_q);
	assign b_raddr     = ADDR_W'(k_q) * ADDR_W'(MATRIX_DIM) + ADDR_W'(j_q);
	assign c_raddr     = ADDR_W'(i_q) * ADDR_W'(MATRIX_DIM) + ADDR_W'(j_q);

	// Loop end conditions.
	assign k_end   = (CNT_W'(k_q) + CNT_W'(1)) == dim_eff;
	assign j_end   = (CNT_W'(j_q) + CNT_W'(1)) == dim_eff;
	assign dim_end = (CNT_W'(i_q) + CNT_W'(1)) == dim_eff;
	assign run_end = dim_end || ((rows_done_q + CNT_W'(1)) == budget_eff);

	// Shared saturating accumulator.
	always_comb begin
		sum_w = {acc_q[47], acc_q} + {{17{prod_q[31]}}, prod_q};
		if (sum_w[48] != sum_w[47])
			acc_next = sum_w[48] ? ACC_MIN : ACC_MAX;
		else
			acc_next = sum_w[47:0];
	end

	// C write port: element writes when idle, write-back at the end of an element.
	always_comb begin
		if (state_q == ST_ACC) begin
			c_we    = k_end;
			c_waddr = c_raddr;
			c_wdata = acc_next;
		end else begin
			c_we    = accept && (req_type == REQ_WR_C) && wr_in_range;
			c_waddr = wr_addr;
			c_wdata = {{24{value[15]}}, value, 8'h00};
		end
	end

	// Matrix memories with registered reads.
	always_ff @(posedge clk) begin
		if (accept && (req_type == REQ_WR_A) && wr_in_range)
			mem_a[wr_addr] <= value;
		a_rd_q <= mem_a[a_raddr];
	end

	always_ff @(posedge clk) begin
		if (accept && (req_type == REQ_WR_B) && wr_in_range)
			mem_b[wr_addr] <= value;
		b_rd_q <= mem_b[b_raddr];
	end

	always_ff @(posedge clk) begin
		if (c_we)
			mem_c[c_waddr] <= c_wdata;
		c_rd_q <= mem_c[c_raddr];
	end

	// Multiplier and accumulator registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			prod_q <= a_rd_q * b_rd_q;
			if (k_q == '0)
				acc_q <= c_rd_q;
		end else if (state_q == ST_ACC) begin
			acc_q <= acc_next;
		end
	end

	// Configuration registers.
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ROWS_PER_RUN) ? {28'd0, rows_per_run_q}
		: {28'd0, dim_in_use_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_in_use_q   <= DIM_IN_USE_RST;
			rows_per_run_q <= ROWS_PER_RUN_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_DIM_IN_USE)
				dim_in_use_q <= pwdata[3:0];
			else
				rows_per_run_q <= pwdata[3:0];
		end
	end

	// Sequencer: walks rows, columns and the inner product index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			next_row_q  <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			rows_done_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (run_req) begin
						if (CNT_W'(next_row_q) >= dim_eff) begin
							next_row_q <= '0;
						end else begin
							i_q         <= next_row_q;
							j_q         <= '0;
							k_q         <= '0;
							rows_done_q <= '0;
							state_q     <= ST_FETCH;
						end
					end
				end
				ST_FETCH: state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_ACC;
				ST_ACC: begin
					if (!k_end) begin
						k_q     <= k_q + IDX_W'(1);
						state_q <= ST_FETCH;
					end else begin
						out_valid_q <= 1'b1;
						k_q         <= '0;
						if (!j_end) begin
							j_q     <= j_q + IDX_W'(1);
							state_q <= ST_FETCH;
						end else begin
							j_q         <= '0;
							i_q         <= i_q + IDX_W'(1);
							rows_done_q <= rows_done_q + CNT_W'(1);
							next_row_q  <= dim_end ? '0 : i_q + IDX_W'(1);
							state_q     <= run_end ? ST_IDLE : ST_FETCH;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result payload, captured with the final accumulate of each element.
	always_ff @(posedge clk) begin
		if ((state_q == ST_ACC) && k_end) begin
			out_row_q   <= 3'(i_q);
			out_col_q   <= 3'(j_q);
			out_value_q <= acc_next;
			last_q      <= j_end && run_end;
			complete_q  <= j_end && dim_end;
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign out_value = out_value_q;
	assign last      = last_q;
	assign complete  = complete_q;

endmodule

@@ bench/preemptible_matrix_mac_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the preemptible matrix multiply-accumulate block.
module preemptible_matrix_mac_tb;
	import pmm_pkg::*;

	localparam int DIM_MAX = MATRIX_DIM_DEF;
	localparam longint ACC_HI = (longint'(1) <<< 47) - 1;
	localparam longint ACC_LO = -ACC_HI - 1;
	localparam logic [2:0] ADDR_DIM = {REG_DIM_IN_USE, 2'b00};
	localparam logic [2:0] ADDR_RPR = {REG_ROWS_PER_RUN, 2'b00};
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES = 32;
	localparam int QUIET_LIMIT = 2000;
	localparam int RAND_ITEMS = 50;
	localparam int SAT_RUNS = 4;

	// Kinds of entry in the stimulus queue.
	typedef enum logic [1:0] {
		ACT_ITEM,
		ACT_CFG,
		ACT_DRAIN
	} act_kind_t;

	typedef struct {
		act_kind_t kind;
		req_t req;
		logic [2:0] row;
		logic [2:0] col;
		logic signed [15:0] value;
		logic [2:0] addr;
		logic [31:0] data;
		bit may_idle;
		int unsigned reps;
	} pend_t;

	typedef struct {
		logic [2:0] row;
		logic [2:0] col;
		logic signed [47:0] value;
		logic last;
		logic complete;
	} c_update_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	logic [1:0] req_type = REQ_WR_A;
	logic [2:0] row = '0;
	logic [2:0] col = '0;
	logic signed [15:0] value = '0;
	logic out_valid;
	logic [2:0] out_row;
	logic [2:0] out_col;
	logic signed [47:0] out_value;
	logic last;
	logic complete;

	preemptible_matrix_mac u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .req_type(req_type), .row(row), .col(col),
		.value(value),
		.out_valid(out_valid), .out_row(out_row), .out_col(out_col),
		.out_value(out_value), .last(last), .complete(complete)
	);

	// Stimulus waiting to be driven, and C updates waiting to be seen.
	pend_t cmd_q[$];
	c_update_t c_updates_q[$];

	// Predicted contents of the block.
	logic signed [15:0] a_mat[DIM_MAX*DIM_MAX];
	logic signed [15:0] b_mat[DIM_MAX*DIM_MAX];
	logic signed [47:0] c_mat[DIM_MAX*DIM_MAX];
	logic [3:0] dim_reg = DIM_IN_USE_RST;
	logic [3:0] rpr_reg = ROWS_PER_RUN_RST;
	int row_ptr = 0;

	// Cells the stimulus has written so far, so that no run reads an unwritten one.
	bit [DIM_MAX*DIM_MAX-1:0] a_set = '0;
	bit [DIM_MAX*DIM_MAX-1:0] b_set = '0;
	bit [DIM_MAX*DIM_MAX-1:0] c_set = '0;

	int mismatch_cnt = 0;
	int quiet_cycles = 0;

	// Driver state.
	pend_t cur_item;
	pend_t nxt;
	bit holding = 1'b0;
	bit draining = 1'b0;
	bit sender_done = 1'b0;
	bit drive_start;
	int gap_left = 0;
	int settle_left = 0;
	int apb_step = 0;

	c_update_t want;

	function automatic int clamp_count(input logic [3:0] v);
		if (v < 1) return 1;
		if (v > DIM_MAX) return DIM_MAX;
		return int'(v);
	endfunction

	// Updates the predicted state for one accepted item and queues the C updates it emits.
	task automatic apply_request(input pend_t it);
		int eff_dim, budget, rows, i, j, k, idx;
		longint acc, s;
		c_update_t upd;
		if (it.req != REQ_RUN) begin
			if (it.row < DIM_MAX && it.col < DIM_MAX) begin
				idx = it.row * DIM_MAX + it.col;
				case (it.req)
					REQ_WR_A: a_mat[idx] = it.value;
					REQ_WR_B: b_mat[idx] = it.value;
					default: c_mat[idx] = 48'(longint'(it.value) * 256);
				endcase
			end
		end else begin
			eff_dim = clamp_count(dim_reg);
			budget = clamp_count(rpr_reg);
			if (row_ptr >= eff_dim) begin
				// A pointer left beyond a shrunken dimension is simply cleared.
				row_ptr = 0;
			end else begin
				rows = (budget < eff_dim - row_ptr) ? budget : eff_dim - row_ptr;
				for (i = row_ptr; i < row_ptr + rows; i++) begin
					for (j = 0; j < eff_dim; j++) begin
						acc = c_mat[i * DIM_MAX + j];
						// Saturate after every add, not only at the end.
						for (k = 0; k < eff_dim; k++) begin
							s = acc + longint'(a_mat[i * DIM_MAX + k]) *
								longint'(b_mat[k * DIM_MAX + j]);
							acc = (s > ACC_HI) ? ACC_HI : ((s < ACC_LO) ? ACC_LO : s);
						end
						c_mat[i * DIM_MAX + j] = acc[47:0];
						upd.row = 3'(i);
						upd.col = 3'(j);
						upd.value = acc[47:0];
						upd.last = (i == row_ptr + rows - 1) && (j == eff_dim - 1);
						upd.complete = upd.last && (row_ptr + rows >= eff_dim);
						c_updates_q.push_back(upd);
					end
				end
				row_ptr = (row_ptr + rows >= eff_dim) ? 0 : row_ptr + rows;
			end
		end
	endtask

	task automatic apply_config(input logic [2:0] addr, input logic [31:0] data);
		if (addr == ADDR_DIM)
			dim_reg = data[3:0];
		else if (addr == ADDR_RPR)
			rpr_reg = data[3:0];
	endtask

	// Helpers that build the stimulus queue.
	task automatic push_item(input req_t req, input logic [2:0] r, input logic [2:0] c,
			input logic signed [15:0] v, input bit may_idle, input int unsigned reps);
		pend_t p;
		p.kind = ACT_ITEM;
		p.req = req;
		p.row = r;
		p.col = c;
		p.value = v;
		p.addr = '0;
		p.data = '0;
		p.may_idle = may_idle;
		p.reps = reps;
		cmd_q.push_back(p);
		case (req)
			REQ_WR_A: a_set[r * DIM_MAX + c] = 1'b1;
			REQ_WR_B: b_set[r * DIM_MAX + c] = 1'b1;
			REQ_WR_C: c_set[r * DIM_MAX + c] = 1'b1;
			default: ;
		endcase
	endtask

	// Waits for the block to go quiet, then writes both registers.
	task automatic set_regs(input logic [3:0] dim_val, input logic [3:0] rpr_val);
		pend_t p;
		p.kind = ACT_DRAIN;
		p.req = REQ_RUN;
		p.row = '0;
		p.col = '0;
		p.value = '0;
		p.may_idle = 1'b0;
		p.reps = 1;
		p.addr = '0;
		p.data = '0;
		cmd_q.push_back(p);
		p.kind = ACT_CFG;
		p.addr = ADDR_DIM;
		p.data = {28'($urandom), dim_val};
		cmd_q.push_back(p);
		p.addr = ADDR_RPR;
		p.data = {28'($urandom), rpr_val};
		cmd_q.push_back(p);
	endtask

	function automatic logic signed [15:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sh0000;
			3: return -16'sd1;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic run_item(input bit may_idle, input int unsigned reps);
		push_item(REQ_RUN, 3'($urandom), 3'($urandom), 16'($urandom), may_idle, reps);
	endtask

	// Writes every cell of the square in use that has not been written yet.
	task automatic fill_cells(input int eff_dim);
		int r, c;
		for (r = 0; r < eff_dim; r++) begin
			for (c = 0; c < eff_dim; c++) begin
				if (!a_set[r * DIM_MAX + c])
					push_item(REQ_WR_A, 3'(r), 3'(c), pick_value(), 1'b1, 1);
				if (!b_set[r * DIM_MAX + c])
					push_item(REQ_WR_B, 3'(r), 3'(c), pick_value(), 1'b1, 1);
				if (!c_set[r * DIM_MAX + c])
					push_item(REQ_WR_C, 3'(r), 3'(c), pick_value(), 1'b1, 1);
			end
		end
	endtask

	// Clock.
	initial begin
		forever #10 clk = ~clk;
	end

	// Stimulus, end of run and verdict.
	initial begin
		int n_rand, phase, n_burst, b;
		logic [3:0] dim_val, rpr_val;

		// Directed part on a 2x2 square with one row per run.
		set_regs(4'd2, 4'd1);
		push_item(REQ_WR_A, 3'd0, 3'd0, 16'sh8000, 1'b1, 1);
		push_item(REQ_WR_A, 3'd0, 3'd1, 16'sh7FFF, 1'b1, 1);
		push_item(REQ_WR_A, 3'd1, 3'd0, 16'sh0000, 1'b1, 1);
		push_item(REQ_WR_A, 3'd1, 3'd1, 16'sh0001, 1'b1, 1);
		push_item(REQ_WR_B, 3'd0, 3'd0, 16'sh7FFF, 1'b1, 1);
		push_item(REQ_WR_B, 3'd0, 3'd1, 16'sh8000, 1'b1, 1);
		push_item(REQ_WR_B, 3'd1, 3'd0, -16'sd1, 1'b1, 1);
		push_item(REQ_WR_B, 3'd1, 3'd1, 16'sh0100, 1'b1, 1);
		push_item(REQ_WR_C, 3'd0, 3'd0, 16'sh7FFF, 1'b1, 1);
		push_item(REQ_WR_C, 3'd0, 3'd1, 16'sh8000, 1'b1, 1);
		push_item(REQ_WR_C, 3'd1, 3'd0, 16'sh0000, 1'b1, 1);
		push_item(REQ_WR_C, 3'd1, 3'd1, -16'sd1, 1'b1, 1);
		// Row 0, then row 1 which completes, then row 0 again with junk in the fields.
		push_item(REQ_RUN, 3'd0, 3'd0, 16'sh0000, 1'b1, 1);
		push_item(REQ_RUN, 3'd7, 3'd7, 16'shFFFF, 1'b1, 1);
		run_item(1'b1, 1);
		// The pointer now sits on row 1; shrinking to one row leaves it stale.
		set_regs(4'd1, 4'd1);
		run_item(1'b1, 1);
		run_item(1'b1, 1);
		// Zero in both registers behaves as one.
		set_regs(4'd0, 4'd0);
		run_item(1'b1, 1);
		// A write outside the square in use is still stored.
		push_item(REQ_WR_A, 3'd7, 3'd7, 16'sh7FFF, 1'b1, 1);

		// Random phases: new register settings, missing cells filled, then a mix.
		// The square stays small so that filling it keeps the item count modest.
		n_rand = 0;
		phase = 0;
		while (n_rand < RAND_ITEMS) begin
			if (phase == 0) begin
				dim_val = 4'd4;
				rpr_val = 4'd15;
			end else if (phase == 1) begin
				dim_val = 4'd3;
				rpr_val = 4'd2;
			end else begin
				dim_val = 4'($urandom_range(0, 4));
				rpr_val = 4'($urandom_range(0, 15));
			end
			set_regs(dim_val, rpr_val);
			fill_cells(clamp_count(dim_val));
			n_burst = (phase < 2) ? 4 : $urandom_range(5, 14);
			for (b = 0; b < n_burst; b++) begin
				if ($urandom_range(0, 99) < 45)
					run_item(1'b1, 1);
				else
					push_item(req_t'($urandom_range(0, 2)), 3'($urandom), 3'($urandom),
						pick_value(), 1'b1, 1);
				n_rand++;
			end
			phase++;
		end

		// Back-to-back runs of the largest product on a single cell, then a
		// negative product pulls C back down.
		// No idling from here on.
		set_regs(4'd1, 4'd1);
		push_item(REQ_WR_A, 3'd0, 3'd0, 16'sh8000, 1'b0, 1);
		push_item(REQ_WR_B, 3'd0, 3'd0, 16'sh8000, 1'b0, 1);
		push_item(REQ_WR_C, 3'd0, 3'd0, 16'sh7FFF, 1'b0, 1);
		run_item(1'b0, SAT_RUNS);
		push_item(REQ_WR_B, 3'd0, 3'd0, 16'sh7FFF, 1'b0, 1);
		run_item(1'b0, 2);

		// Reset.
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for the sender, then for the last C updates, then a short tail.
		while (!sender_done) @(posedge clk);
		while (c_updates_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (c_updates_q.size() != 0)
			mismatch_cnt++;
		if (mismatch_cnt == 0)
			$display("preemptible_matrix_mac: match");
		else
			$display("preemptible_matrix_mac: mismatch");
		$finish;
	end

	// Driver: commands, register writes and the hold-offs between phases.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req_type <= REQ_WR_A;
			row <= '0;
			col <= '0;
			value <= '0;
			psel <= 1'b0;
			penable <= 1'b0;
			pwrite <= 1'b0;
			paddr <= '0;
			pwdata <= '0;
			holding = 1'b0;
			draining = 1'b0;
			sender_done = 1'b0;
			gap_left = 0;
			settle_left = 0;
			apb_step = 0;
		end else begin
			drive_start = start;
			// Item taken by the block at this edge.
			if (start && !busy) begin
				apply_request(cur_item);
				if (cur_item.reps > 1) begin
					cur_item.reps = cur_item.reps - 1;
				end else begin
					holding = 1'b0;
					drive_start = 1'b0;
					if (cur_item.may_idle && $urandom_range(0, 3) == 0)
						gap_left = $urandom_range(1, 9);
				end
			end
			// Register write completing at this edge.
			if (psel && penable && pwrite && pready)
				apply_config(paddr, pwdata);
			// Sequence the next step.
			if (apb_step == 1) begin
				penable <= 1'b1;
				apb_step = 2;
			end else if (apb_step == 2) begin
				psel <= 1'b0;
				penable <= 1'b0;
				pwrite <= 1'b0;
				apb_step = 0;
			end else if (!holding) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (draining) begin
					if (c_updates_q.size() == 0 && !busy) begin
						if (settle_left > 0)
							settle_left--;
						else
							draining = 1'b0;
					end
				end else if (cmd_q.size() > 0) begin
					nxt = cmd_q.pop_front();
					case (nxt.kind)
						ACT_ITEM: begin
							cur_item = nxt;
							req_type <= nxt.req;
							row <= nxt.row;
							col <= nxt.col;
							value <= nxt.value;
							drive_start = 1'b1;
							holding = 1'b1;
						end
						ACT_CFG: begin
							psel <= 1'b1;
							pwrite <= 1'b1;
							paddr <= nxt.addr;
							pwdata <= nxt.data;
							apb_step = 1;
						end
						default: begin
							draining = 1'b1;
							settle_left = SETTLE_CYCLES;
						end
					endcase
				end else begin
					sender_done = 1'b1;
				end
			end
			start <= drive_start;
		end
	end

	// Monitor: every C update is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid) begin
			if (c_updates_q.size() == 0) begin
				if (mismatch_cnt < 10)
					$display("unexpected C update: row %0d col %0d value %0d last %0b complete %0b",
						out_row, out_col, out_value, last, complete);
				mismatch_cnt++;
			end else begin
				want = c_updates_q.pop_front();
				if (out_row !== want.row || out_col !== want.col ||
						out_value !== want.value || last !== want.last ||
						complete !== want.complete) begin
					if (mismatch_cnt < 10)
						$display({"C update differs: expected row %0d col %0d value %0d ",
							"last %0b complete %0b, got row %0d col %0d value %0d ",
							"last %0b complete %0b"},
							want.row, want.col, want.value, want.last, want.complete,
							out_row, out_col, out_value, last, complete);
					mismatch_cnt++;
				end
			end
		end
	end

	// Watchdog on cycles in which nothing moves.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || out_valid || (psel && penable)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("preemptible_matrix_mac: mismatch");
				$finish;
			end
		end
	end

endmodule

@@ files.f @@
rtl/pmm_pkg.sv
rtl/preemptible_matrix_mac.sv
bench/preemptible_matrix_mac_tb.sv
